/* rtl/gnen_pkg.sv */
// Shared constants and register codes for the equal-neighbor energy block.
package gnen_pkg;

  // Default sizing of the frame.
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned ColorBitsDef = 16;

  // Fixed field widths.
  localparam int unsigned ColorW  = 16;
  localparam int unsigned SizeW   = 11;
  localparam int unsigned PairsW  = 21;
  localparam int unsigned EnergyW = 22;

  // Configuration port.
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // Register indexes.
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(1024);

endpackage

/* rtl/gnen_stream_if.sv */
// Valid/ready stream interfaces for cell items and frame result items.
interface gnen_cell_if;
  logic                         valid;
  logic                         ready;
  logic [gnen_pkg::ColorW-1:0]  color;

  modport source (output valid, output color, input ready);
  modport sink   (input valid, input color, output ready);
endinterface

interface gnen_result_if;
  logic                          valid;
  logic                          ready;
  logic [gnen_pkg::PairsW-1:0]   equal_pairs;
  logic signed [gnen_pkg::EnergyW-1:0] energy;

  modport source (output valid, output equal_pairs, output energy, input ready);
  modport sink   (input valid, input equal_pairs, input energy, output ready);
endinterface

/* rtl/grid_equal_neighbour_energy.sv */
// Open-boundary Potts energy of a color grid streamed in raster order.
//
// Usage: cells enter on in_i (valid/ready), one color label per item, in raster
// order, grid_width cells per row and grid_height rows per frame. After the last
// cell of a frame one result item leaves on out_o: the number of horizontally or
// vertically adjacent equal-color pairs, and the energy, minus that count.
// Configuration goes through the APB port: grid_width at address 0, grid_height
// at address 4 (0 acts as 1, values above the maximum act as the maximum). Any
// write restarts the frame; write only while the block is idle.
// Throughput: one cell per cycle, sustained while no held result stalls stage 1.
// The line store is a single memory read at accept and written back as the item
// leaves stage 1, with a bypass when the same column is read and written in the
// same cycle (one-cell-wide grids). Results pass stage 1, then the output register.
// Reset: counters, left neighbor and pair total clear, both size registers go
// to 1024; the line store is not cleared (row 0 never uses it).
// Stall: a stalled result holds in the output register; cells keep flowing
// until the next frame's last cell reaches the accumulate stage, then in_i
// drops ready.
module grid_equal_neighbour_energy #(
  parameter int unsigned MAX_WIDTH  = gnen_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = gnen_pkg::MaxHeightDef,
  parameter int unsigned COLOR_BITS = gnen_pkg::ColorBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gnen_pkg::AddrW-1:0]  paddr,
  input  logic [gnen_pkg::DataW-1:0]  pwdata,
  output logic [gnen_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  gnen_cell_if.sink                   in_i,
  gnen_result_if.source               out_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned SW = (COLOR_BITS < gnen_pkg::ColorW) ? COLOR_BITS
                                                               : gnen_pkg::ColorW;

  // ---------------- configuration registers ----------------
  logic [gnen_pkg::SizeW-1:0] width_q, height_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gnen_pkg::SizeReset;
      height_q <= gnen_pkg::SizeReset;
    end else if (cfg_wr) begin
      if (paddr[2] == gnen_pkg::RegWidth) begin
        width_q <= pwdata[gnen_pkg::SizeW-1:0];
      end else begin
        height_q <= pwdata[gnen_pkg::SizeW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == gnen_pkg::RegWidth) begin
      prdata[gnen_pkg::SizeW-1:0] = width_q;
    end else begin
      prdata[gnen_pkg::SizeW-1:0] = height_q;
    end
  end

  // Clamped sizes minus one, as last-column / last-row marks.
  logic [31:0] w_m1, h_m1;
  always_comb begin
    if (width_q == '0) begin
      w_m1 = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_m1 = MAX_WIDTH - 1;
    end else begin
      w_m1 = 32'(width_q) - 32'd1;
    end
    if (height_q == '0) begin
      h_m1 = '0;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_m1 = MAX_HEIGHT - 1;
    end else begin
      h_m1 = 32'(height_q) - 32'd1;
    end
  end

  // ---------------- accept stage: counters, left compare, store read ----------------
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [SW-1:0] left_q;
  logic [SW-1:0] in_color;
  logic          last_col, last_row, accept, in_ready;

  assign in_color = in_i.color[SW-1:0];
  assign last_col = (col_q == w_m1[CW-1:0]);
  assign last_row = (row_q == h_m1[RW-1:0]);
  assign accept   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Accumulate stage registers.
  logic          s1_valid_q, s1_left_q, s1_up_q, s1_last_q, fwd_q;
  logic [CW-1:0] s1_col_q;
  logic [SW-1:0] s1_color_q, fwd_color_q, rdata_q;
  logic          s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (cfg_wr) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (accept) begin
      left_q <= in_color;
      if (last_col) begin
        col_q <= '0;
        if (last_row) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + RW'(1);
        end
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Line store: one read at accept, one write-back as the item leaves stage 1.
  logic [SW-1:0] row_store [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      row_store[s1_col_q] <= s1_color_q;
    end
    if (accept) begin
      rdata_q <= row_store[col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_left_q  <= 1'b0;
      s1_up_q    <= 1'b0;
      s1_last_q  <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_left_q  <= (col_q != '0) && (left_q == in_color);
      s1_up_q    <= (row_q != '0);
      s1_last_q  <= last_col && last_row;
      // same column being written this edge: take the write data instead
      fwd_q      <= s1_go && (s1_col_q == col_q);
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q    <= col_q;
      s1_color_q  <= in_color;
      fwd_color_q <= s1_color_q;
    end
  end

  // ---------------- stage 1: vertical compare and accumulate ----------------
  logic [SW-1:0]               up_color;
  logic [1:0]                  inc;
  logic [gnen_pkg::PairsW-1:0] total_q, sum;
  logic                        out_valid_q;

  assign s1_go    = s1_valid_q && !(s1_last_q && out_valid_q && !out_o.ready);
  assign in_ready = !s1_valid_q || s1_go;
  assign up_color = fwd_q ? fwd_color_q : rdata_q;
  assign inc      = {1'b0, s1_left_q} + {1'b0, (s1_up_q && (up_color == s1_color_q))};
  assign sum      = total_q + gnen_pkg::PairsW'(inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        total_q <= '0;
      end else if (s1_go) begin
        if (s1_last_q) begin
          total_q <= '0;
        end else begin
          total_q <= sum;
        end
      end
      // a new result may replace the one being taken in the same cycle
      if (!cfg_wr && s1_go && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  logic [gnen_pkg::PairsW-1:0]  pairs_q;
  logic [gnen_pkg::EnergyW-1:0] energy_q;

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      pairs_q  <= sum;
      energy_q <= gnen_pkg::EnergyW'(0) - {1'b0, sum};
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.equal_pairs = pairs_q;
  assign out_o.energy      = $signed(energy_q);

endmodule

/* verif/pair_count_monitor.sv */
// Monitor for the equal-neighbor energy block: tracks the register and cell ports, predicts frame results, compares.
module pair_count_monitor
  import gnen_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic [DataW-1:0] prdata,
  gnen_cell_if             cell_bus,
  gnen_result_if           result_bus,
  output int unsigned      mismatches_o,
  output int unsigned      results_due_o
);

  typedef struct packed {
    logic [PairsW-1:0]         equal_pairs;
    logic signed [EnergyW-1:0] energy;
  } frame_result_t;

  // Shadow of the block: previous row, left neighbor, position, running count.
  logic [ColorW-1:0] line_colors [MaxWidthDef];
  logic [ColorW-1:0] west_color;
  int unsigned       row_at;
  int unsigned       col_at;
  logic [PairsW-1:0] pair_count;
  logic [SizeW-1:0]  width_reg;
  logic [SizeW-1:0]  height_reg;
  frame_result_t     results_due [$];

  // 0 acts as 1, anything above the maximum acts as the maximum
  function automatic int unsigned span(input logic [SizeW-1:0] raw, input int unsigned limit);
    if (raw == 0) return 1;
    return (raw > limit) ? limit : int'(raw);
  endfunction

  function automatic void restart_tally();
    west_color = '0;
    row_at     = 0;
    col_at     = 0;
    pair_count = '0;
  endfunction

  // One cell in raster order; returns 1 with the frame result on the last cell.
  function automatic bit tally_cell(input logic [ColorW-1:0] color, output frame_result_t res);
    int unsigned w;
    int unsigned h;
    w   = span(width_reg, MaxWidthDef);
    h   = span(height_reg, MaxHeightDef);
    res = '0;
    if (col_at > 0 && west_color == color) pair_count++;
    if (row_at > 0 && line_colors[col_at] == color) pair_count++;
    line_colors[col_at] = color;
    west_color          = color;
    if (col_at + 1 < w) begin
      col_at++;
      return 1'b0;
    end
    col_at = 0;
    if (row_at + 1 < h) begin
      row_at++;
      return 1'b0;
    end
    res.equal_pairs = pair_count;
    res.energy      = -$signed({1'b0, pair_count});
    restart_tally();
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_result_t want;
    frame_result_t got;
    logic [SizeW-1:0] reg_val;
    if (!rst_ni) begin
      width_reg  = SizeReset;
      height_reg = SizeReset;
      restart_tally();
      results_due.delete();
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        got.equal_pairs = result_bus.equal_pairs;
        got.energy      = result_bus.energy;
        if (results_due.size() == 0) begin
          $error("result item with none due: equal_pairs %0d energy %0d",
                 got.equal_pairs, got.energy);
          mismatches_o++;
        end else begin
          want = results_due.pop_front();
          if (got.equal_pairs !== want.equal_pairs) begin
            $error("equal_pairs: expected %0d, got %0d", want.equal_pairs, got.equal_pairs);
            mismatches_o++;
          end
          if (got.energy !== want.energy) begin
            $error("energy: expected %0d, got %0d", want.energy, got.energy);
            mismatches_o++;
          end
        end
      end
      if (cell_bus.valid && cell_bus.ready) begin
        if (tally_cell(cell_bus.color, want)) results_due.push_back(want);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if ((paddr >> 2) == RegWidth) width_reg = pwdata[SizeW-1:0];
          else if ((paddr >> 2) == RegHeight) height_reg = pwdata[SizeW-1:0];
          // any write drops the frame in progress
          restart_tally();
        end else begin
          reg_val = ((paddr >> 2) == RegWidth) ? width_reg : height_reg;
          if (prdata !== DataW'(reg_val)) begin
            $error("prdata: expected %0d, got %0d", reg_val, prdata);
            mismatches_o++;
          end
        end
      end
    end
    results_due_o = results_due.size();
  end

endmodule

/* verif/testbench.sv */
// Top of the equal-neighbor energy testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  import gnen_pkg::*;

  localparam int unsigned HoldCycles  = 400;   // long receiver hold-off
  localparam int unsigned StallLimit  = 4000;  // cycles without any transfer
  localparam int unsigned RandomCells = 700;
  localparam int unsigned DrainCycles = 6;     // lets partial-frame cells drain

  typedef enum int unsigned {TwoTone, Noise, Speckled, Flat} paint_e;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic             pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;

  int unsigned mismatches;
  int unsigned results_due;
  int unsigned cells_sent;
  bit          sender_idles;
  bit          receiver_idles;
  bit          hold_off;       // set by stimulus, cleared by the receiver

  gnen_cell_if   cell_bus ();
  gnen_result_if result_bus ();

  grid_equal_neighbour_energy uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (cell_bus),
    .out_o   (result_bus)
  );

  pair_count_monitor pair_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .cell_bus      (cell_bus),
    .result_bus    (result_bus),
    .mismatches_o  (mismatches),
    .results_due_o (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Effective grid size the block will use for a raw register value.
  function automatic int unsigned cells_of(input logic [SizeW-1:0] raw, input int unsigned limit);
    return (raw == 0) ? 1 : (raw > limit) ? limit : int'(raw);
  endfunction

  // APB access: setup cycle, then access cycle until pready.
  task automatic reg_access(input logic index, input bit is_write, input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= AddrW'({index, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits are junk; only the low SizeW bits are the register.
  task automatic write_size(input logic index, input logic [SizeW-1:0] raw);
    logic [DataW-1:0] value;
    value            = $urandom();
    value[SizeW-1:0] = raw;
    reg_access(index, 1'b1, value);
  endtask

  // Wait until every predicted result is out, then let partial-frame cells drain.
  task automatic wait_idle();
    do @(negedge clk_i); while (results_due != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_sizes(input logic [SizeW-1:0] w_raw, input logic [SizeW-1:0] h_raw);
    cell_bus.valid <= 1'b0;
    wait_idle();
    write_size(RegWidth, w_raw);
    write_size(RegHeight, h_raw);
    reg_access(RegWidth, 1'b0, '0);
    reg_access(RegHeight, 1'b0, '0);
  endtask

  // One cell item; valid stays up afterwards so back-to-back cells need no gap.
  task automatic send_cell(input logic [ColorW-1:0] color);
    while (sender_idles && $urandom_range(99) < 20) begin
      cell_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cell_bus.valid <= 1'b1;
    cell_bus.color <= color;
    do @(posedge clk_i); while (!cell_bus.ready);
    cells_sent++;
  endtask

  // Frame content: mostly few colors so equal pairs are common, sometimes noise.
  task automatic send_frame(input int unsigned cells);
    logic [ColorW-1:0] base;
    logic [ColorW-1:0] other;
    paint_e            paint;
    base  = ColorW'($urandom());
    other = ColorW'($urandom());
    paint = paint_e'($urandom_range(3));
    for (int unsigned n = 0; n < cells; n++) begin
      case (paint)
        TwoTone:  send_cell($urandom_range(1) ? base : other);
        Noise:    send_cell(ColorW'($urandom()));
        Speckled: send_cell(($urandom_range(9) == 0) ? ColorW'($urandom()) : base);
        default:  send_cell(base);
      endcase
    end
  endtask

  task automatic run_phase(input logic [SizeW-1:0] w_raw, input logic [SizeW-1:0] h_raw,
                           input int unsigned frames, input bit cut_short, input bit squeeze);
    int unsigned cells;
    set_sizes(w_raw, h_raw);
    cells = cells_of(w_raw, MaxWidthDef) * cells_of(h_raw, MaxHeightDef);
    // receiver stalls while the sender keeps pushing: the block must back up
    if (squeeze) hold_off = 1'b1;
    repeat (frames) send_frame(cells);
    // a partial frame left behind is dropped by the next register write
    if (cut_short && cells > 1) send_frame($urandom_range(1, cells - 1));
  endtask

  function automatic logic [SizeW-1:0] pick_size();
    if ($urandom_range(9) == 0) return '0;
    if ($urandom_range(9) == 0) return SizeW'(8);
    return SizeW'($urandom_range(1, 6));
  endfunction

  // Result side: random back-pressure, or a long hold-off on request.
  initial begin : result_taker
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        result_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        result_bus.ready <= !(receiver_idles && $urandom_range(99) < 20);
      end
    end
  end

  // Ends the run if nothing moves on any port for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((cell_bus.valid && cell_bus.ready) || (result_bus.valid && result_bus.ready) || psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("grid_equal_neighbour_energy verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned start;
    int unsigned phase;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    cell_bus.valid <= 1'b0;
    cell_bus.color <= '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    hold_off       = 1'b0;
    cells_sent     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 2x2: all equal gives every bond, checkerboard gives none
    set_sizes(SizeW'(2), SizeW'(2));
    repeat (4) send_cell(16'hFFFF);
    send_cell(16'h0000);
    send_cell(16'hFFFF);
    send_cell(16'hFFFF);
    send_cell(16'h0000);

    // zero registers act as 1: every cell is a frame on its own
    set_sizes('0, '0);
    send_cell(16'h0000);
    send_cell(16'hFFFF);
    send_cell(16'hAAAA);

    // single column: vertical bonds only, line store read and written per cell
    set_sizes(SizeW'(1), SizeW'(3));
    repeat (3) send_cell(16'h5555);

    // single row: horizontal bonds only
    set_sizes(SizeW'(3), SizeW'(1));
    send_cell(16'h1234);
    send_cell(16'h1234);
    send_cell(16'h4321);

    // frame cut off by a write of an unchanged value; next cell starts a new frame
    set_sizes(SizeW'(3), SizeW'(2));
    repeat (4) send_cell(16'h0007);
    cell_bus.valid <= 1'b0;
    wait_idle();
    write_size(RegHeight, SizeW'(2));
    send_cell(16'h0007);
    send_cell(16'h0007);
    send_cell(16'h0008);
    send_cell(16'h0007);
    send_cell(16'h0008);
    send_cell(16'h0008);

    // random small grids; phase 2 squeezes the block, phases 4..7 run flat out
    start = cells_sent;
    phase = 0;
    while (cells_sent - start < RandomCells) begin
      sender_idles   = !(phase inside {[2:7]});
      receiver_idles = !(phase inside {[4:7]});
      if (phase == 2)
        run_phase(SizeW'(2), SizeW'(2), 8, 1'b0, 1'b1);
      else
        run_phase(pick_size(), pick_size(), $urandom_range(1, 4), $urandom_range(3) == 0, 1'b0);
      phase++;
    end

    cell_bus.valid <= 1'b0;
    do @(negedge clk_i); while (results_due != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("grid_equal_neighbour_energy verification clean");
    else
      $display("grid_equal_neighbour_energy verification failed");
    $finish;
  end

endmodule
